// ===== rtl/bfsr_pkg.sv =====
// Package for the block frame sender: opcodes, phase codes, frame characters
// and the codes that tag a word on its way to the output register.
// Used by block_frame_sender_with_retry; depends on nothing.
`timescale 1ns / 1ps

package bfsr_pkg;

  // Default block size in bytes
  localparam int BLOCK_DEFAULT = 256;

  // Input opcodes
  localparam logic [2:0] OP_BYTE    = 3'd0;
  localparam logic [2:0] OP_SLOT    = 3'd1;
  localparam logic [2:0] OP_ACK     = 3'd2;
  localparam logic [2:0] OP_NACK    = 3'd3;
  localparam logic [2:0] OP_TIMEOUT = 3'd4;

  // Transfer phases
  localparam logic [1:0] PH_COLLECT = 2'd0;
  localparam logic [1:0] PH_SEND    = 2'd1;
  localparam logic [1:0] PH_WAIT    = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  // Frame characters
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CHECK_START = CH_DOLLAR ^ CH_F;
  localparam logic [7:0] CHECK_MSB   = 8'h80;

  // Register map
  localparam logic REG_IMAGE_LENGTH = 1'b0;
  localparam logic [23:0] IMAGE_LENGTH_RESET = 24'd1;

  // Kind of word held in the pipe stage
  localparam logic [2:0] KD_FRAME_START = 3'd0;
  localparam logic [2:0] KD_LITERAL     = 3'd1;
  localparam logic [2:0] KD_DATA        = 3'd2;
  localparam logic [2:0] KD_STAR        = 3'd3;
  localparam logic [2:0] KD_CHECK       = 3'd4;
  localparam logic [2:0] KD_DONE        = 3'd5;

  // Word waiting between the decode stage and the output register
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] lit;
  } pipe_word_t;

endpackage

// ===== rtl/block_frame_sender_with_retry.sv =====
// Top level of the block frame sender with retry: decode stage, block
// buffer memory and output register. Depends on bfsr_pkg.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): tuser carries the opcode (image byte, transmit slot,
//   reply ack, reply nack, reply timeout), tdata the image byte. Every word
//   is taken; words that do not fit the current phase are dropped silently.
//   Output stream (m_*): tdata is the frame byte, tlast marks the checksum
//   that closes a frame, tuser marks the single word that reports the end of
//   the transfer (tdata zero then).
//   APB port: register 0 at byte address 0 holds image_length (24 bits).
//   Write it only while the block is idle.
//   Path: an input word is decoded and its block buffer byte read into the
//   pipe stage, which holds it until the output register takes it.
//   Throughput: one word per cycle while the receiver does not stall; the
//   block buffer has one write and one registered read port, and the checksum
//   is folded in as words enter the output register.
//   Reset clears all control state and sets image_length to 1; the buffer
//   contents are left as they are and need no clearing pass.
//   When the receiver stalls, the pipe stage and output register fill and
//   s_tready drops; nothing is lost or repeated.
module block_frame_sender_with_retry #(
  parameter int BLOCK = bfsr_pkg::BLOCK_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] image_byte
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] tx_byte
  output logic        m_tlast,
  output logic        m_tuser,   // [0] update_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FW = $clog2(BLOCK + 1);
  localparam int AW = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int TW = $clog2(BLOCK + 5);

  logic [23:0] image_length;

  // Transfer state
  logic [FW-1:0] block_fill, block_fill_next;
  logic [23:0]   bytes_sent, bytes_sent_next;
  logic [TW-1:0] tx_position, tx_position_next;
  logic [1:0]    phase, phase_next;
  logic [7:0]    running_check;

  // Block buffer
  logic [7:0]    block_store [BLOCK];
  logic [7:0]    rd_data;
  logic          store_we;

  // Pipe stage
  logic          p_valid;
  bfsr_pkg::pipe_word_t p_word, p_word_next;
  logic          issue;

  logic          accept;
  logic          out_free;
  logic          advance;
  logic [FW-1:0] fill_inc;
  logic [23:0]   sent_inc;
  logic [TW-1:0] fill_ext;
  logic [AW-1:0] rd_addr;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bfsr_pkg::REG_IMAGE_LENGTH) ? {8'd0, image_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= bfsr_pkg::IMAGE_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bfsr_pkg::REG_IMAGE_LENGTH) begin
      image_length <= pwdata[23:0];
    end
  end

  // Handshake
  assign out_free = !m_tvalid || m_tready;
  assign advance  = p_valid && out_free;
  assign s_tready = !p_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  assign fill_inc = block_fill + FW'(1);
  assign sent_inc = bytes_sent + 24'd1;
  assign fill_ext = TW'(block_fill);
  assign rd_addr  = AW'(tx_position - TW'(2));

  // Decode one word against the phase
  always_comb begin
    block_fill_next  = block_fill;
    bytes_sent_next  = bytes_sent;
    tx_position_next = tx_position;
    phase_next       = phase;
    store_we         = 1'b0;
    issue            = 1'b0;
    p_word_next.kind = bfsr_pkg::KD_LITERAL;
    p_word_next.lit  = 8'd0;
    unique case (phase)
      bfsr_pkg::PH_COLLECT: begin
        if (s_tuser == bfsr_pkg::OP_BYTE) begin
          store_we        = 1'b1;
          block_fill_next = fill_inc;
          bytes_sent_next = sent_inc;
          if (fill_inc >= FW'(BLOCK) || sent_inc >= image_length) begin
            tx_position_next = '0;
            phase_next       = bfsr_pkg::PH_SEND;
          end
        end
      end
      bfsr_pkg::PH_SEND: begin
        if (s_tuser == bfsr_pkg::OP_SLOT) begin
          tx_position_next = tx_position + TW'(1);
          issue            = 1'b1;
          if (tx_position == TW'(0)) begin
            p_word_next.kind = bfsr_pkg::KD_FRAME_START;
            p_word_next.lit  = bfsr_pkg::CH_DOLLAR;
          end else if (tx_position == TW'(1)) begin
            p_word_next.lit  = bfsr_pkg::CH_F;
          end else if (tx_position < fill_ext + TW'(2)) begin
            p_word_next.kind = bfsr_pkg::KD_DATA;
          end else if (tx_position == fill_ext + TW'(2)) begin
            p_word_next.kind = bfsr_pkg::KD_STAR;
            p_word_next.lit  = bfsr_pkg::CH_STAR;
          end else begin
            p_word_next.kind = bfsr_pkg::KD_CHECK;
            phase_next       = bfsr_pkg::PH_WAIT;
          end
        end
      end
      bfsr_pkg::PH_WAIT: begin
        if (s_tuser == bfsr_pkg::OP_ACK) begin
          if (bytes_sent >= image_length) begin
            phase_next       = bfsr_pkg::PH_DONE;
            issue            = 1'b1;
            p_word_next.kind = bfsr_pkg::KD_DONE;
          end else begin
            block_fill_next = '0;
            phase_next      = bfsr_pkg::PH_COLLECT;
          end
        end else if (s_tuser == bfsr_pkg::OP_NACK || s_tuser == bfsr_pkg::OP_TIMEOUT) begin
          tx_position_next = '0;
          phase_next       = bfsr_pkg::PH_SEND;
        end
      end
      default: begin
        // transfer finished: drop everything until reset
      end
    endcase
  end

  // Advance transfer state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      block_fill  <= '0;
      bytes_sent  <= '0;
      tx_position <= '0;
      phase       <= bfsr_pkg::PH_COLLECT;
    end else if (accept) begin
      block_fill  <= block_fill_next;
      bytes_sent  <= bytes_sent_next;
      tx_position <= tx_position_next;
      phase       <= phase_next;
    end
  end

  // Block buffer: write while collecting, registered read while sending
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      block_store[block_fill[AW-1:0]] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= block_store[rd_addr];
    end
  end

  // Pipe stage: hold the word until the output register frees
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= issue;
    end else if (out_free) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_word <= p_word_next;
    end
  end

  // Output register; fold each word into the checksum as it enters
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      running_check <= bfsr_pkg::CHECK_START;
    end else if (advance) begin
      m_tvalid <= 1'b1;
      unique case (p_word.kind)
        bfsr_pkg::KD_FRAME_START: running_check <= bfsr_pkg::CHECK_START;
        bfsr_pkg::KD_DATA:        running_check <= running_check ^ rd_data;
        bfsr_pkg::KD_STAR:        running_check <= running_check ^ bfsr_pkg::CH_STAR;
        default:                  running_check <= running_check;
      endcase
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tlast <= 1'b0;
      m_tuser <= 1'b0;
      unique case (p_word.kind)
        bfsr_pkg::KD_DATA:  m_tdata <= rd_data;
        bfsr_pkg::KD_CHECK: begin
          m_tdata <= running_check | bfsr_pkg::CHECK_MSB;
          m_tlast <= 1'b1;
        end
        bfsr_pkg::KD_DONE: begin
          m_tdata <= 8'd0;
          m_tuser <= 1'b1;
        end
        default:            m_tdata <= p_word.lit;
      endcase
    end
  end

endmodule

// ===== rtl/bfsr_checker.sv =====
// Port-level checker for block_frame_sender_with_retry, with its bind.
// Sees the top level's ports only; depends on nothing else.
`timescale 1ns / 1ps

module bfsr_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser,
  input logic       pready
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output word changed while stalled");

  // The end-of-transfer word carries no frame byte
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0 && !m_tlast)
    else $error("done word carries frame data");

  // A checksum always has bit 7 set
  a_check_msb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7])
    else $error("checksum without bit 7");

  // Nothing follows the done word until reset
  a_done_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser |=> !m_tvalid)
    else $error("word after end of transfer");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind block_frame_sender_with_retry bfsr_checker u_bfsr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
